### rtl/brag_pkg.sv
// Package with AES-128 types, constants and round functions for the address generator.
package brag_pkg;

  localparam int unsigned KeyW    = 128;
  localparam int unsigned RandW   = 24;
  localparam int unsigned AddrW   = 48;
  localparam int unsigned NRounds = 10;
  localparam int unsigned IdxW    = 1;

  localparam logic [IdxW-1:0] RegIrkLow  = 1'b0;
  localparam logic [IdxW-1:0] RegIrkHigh = 1'b1;

  localparam logic [7:0] PrandClr = 8'h7f;
  localparam logic [7:0] PrandSet = 8'h40;

  typedef logic [127:0] block_t;

  // Round data that moves from one stage to the next.
  typedef struct packed {
    logic               valid;
    block_t             state;
    block_t             rkey;
    logic [7:0]         rcon;
    logic [RandW-1:0]   prand;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Byte i of a block (standard AES order) sits in bits 127-8i : 120-8i.
  function automatic logic [7:0] get_byte(block_t b, int unsigned i);
    return b[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes, ShiftRows and, unless last, MixColumns.
  function automatic block_t round_fn(block_t s, logic last);
    block_t      sb;
    block_t      sr;
    block_t      mc;
    logic [7:0]  a0, a1, a2, a3, all;
    for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = SBOX[get_byte(s, i)];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sr[127-8*(r+4*c) -: 8] = get_byte(sb, r + 4*((c + r) % 4));
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(sr, 4*c);
      a1 = get_byte(sr, 4*c+1);
      a2 = get_byte(sr, 4*c+2);
      a3 = get_byte(sr, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      mc[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      mc[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      mc[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      mc[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return last ? sr : mc;
  endfunction

  function automatic block_t key_next(block_t k, logic [7:0] rcon);
    block_t n;
    n[127:120] = k[127:120] ^ SBOX[get_byte(k, 13)] ^ rcon;
    n[119:112] = k[119:112] ^ SBOX[get_byte(k, 14)];
    n[111:104] = k[111:104] ^ SBOX[get_byte(k, 15)];
    n[103:96]  = k[103:96]  ^ SBOX[get_byte(k, 12)];
    for (int i = 4; i < 16; i++)
      n[127-8*i -: 8] = get_byte(k, i) ^ n[127-8*(i-4) -: 8];
    return n;
  endfunction

endpackage

### rtl/ble_resolvable_address_gen.sv
// Top level of the resolvable private address generator.
// One word is accepted whenever start_i is high and busy_o is low; busy_o is
// tied low, so a new word may enter on every cycle. The word passes an input
// stage that forms prand and applies the initial key, then ten AES round
// stages, one register each: the result appears with done_o from the last round
// register and is held only while done_o is high, since the receiver
// cannot stall. The key registers are written through cfg_we_i and must only
// change while no word is in flight.
module ble_resolvable_address_gen (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [brag_pkg::RandW-1:0]    random_value_i,
  output logic                          done_o,
  output logic [brag_pkg::AddrW-1:0]    address_o,
  output logic [brag_pkg::RandW-1:0]    hash_value_o,
  input  logic                          cfg_we_i,
  input  logic [brag_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [63:0]                   cfg_data_i
);
  import brag_pkg::*;

  logic [63:0] irk_low_q, irk_high_q;
  stage_t      pipe [NRounds+1];
  stage_t      in_q;
  block_t      key;
  logic [RandW-1:0] prand;

  // The key registers reset to zero, and the all-zero key is legal.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irk_low_q  <= '0;
      irk_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegIrkLow:  irk_low_q  <= cfg_data_i;
        RegIrkHigh: irk_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The key read as a big-endian string is just the identity key number.
  assign key   = {irk_high_q, irk_low_q};
  assign prand = {random_value_i[RandW-1] & PrandClr[7] & 1'b0,
                  PrandSet[6], random_value_i[RandW-3:0]};

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else begin
      in_q.valid <= start_i;
      in_q.state <= {104'd0, prand} ^ key;
      in_q.rkey  <= key;
      in_q.rcon  <= 8'h01;
      in_q.prand <= prand;
    end
  end

  assign pipe[0] = in_q;

  for (genvar r = 0; r < NRounds; r++) begin : g_round
    brag_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .last_i (r == NRounds - 1),
      .stage_i(pipe[r]),
      .stage_o(pipe[r+1])
    );
  end

  assign done_o       = pipe[NRounds].valid;
  assign hash_value_o = pipe[NRounds].state[RandW-1:0];
  assign address_o    = {pipe[NRounds].prand, pipe[NRounds].state[RandW-1:0]};
endmodule

### rtl/brag_round.sv
// One registered AES round stage with its key schedule step.
module brag_round (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            last_i,
  input  brag_pkg::stage_t stage_i,
  output brag_pkg::stage_t stage_o
);
  import brag_pkg::*;

  stage_t stage_q;
  block_t key_d;

  assign key_d = key_next(stage_i.rkey, stage_i.rcon);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q.valid <= stage_i.valid;
      stage_q.rkey  <= key_d;
      stage_q.rcon  <= xtime(stage_i.rcon);
      stage_q.prand <= stage_i.prand;
      stage_q.state <= round_fn(stage_i.state, last_i) ^ key_d;
    end
  end

  assign stage_o = stage_q;
endmodule
